### rtl/fwwg_pkg.sv
// Shared types, widths and constants of the FIR window weight generator.
package fwwg_pkg;

    // Field and register widths
    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int M_W        = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Phase and divider widths
    localparam int PH_W    = 32;
    localparam int NUM_W   = M_W + PH_W;
    localparam int DIV_LAT = PH_W;

    // CORDIC sizing
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam int COR_LAT      = CORDIC_STEPS + 2;

    // Parameter defaults
    localparam int DEF_MAX_LENGTH    = 4096;
    localparam int DEF_FRACTION_BITS = 30;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APPLY  = 2'd2;

    // Window kinds
    localparam logic [KIND_W-1:0] KIND_RECT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BARTLETT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HANN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BLACKMAN = 3'd4;

    localparam logic [M_W-1:0] LENGTH_RESET = 13'd64;

    // Q1.30 constants
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd1073741824;
    localparam logic signed [DATA_W-1:0] C054  = 32'sd579820585;
    localparam logic signed [DATA_W-1:0] C046  = 32'sd493921239;
    localparam logic signed [DATA_W-1:0] C042  = 32'sd450971566;
    localparam logic signed [DATA_W-1:0] C008  = 32'sd85899346;
    localparam logic signed [DATA_W-1:0] C050  = 32'sd536870912;
    localparam logic signed [DATA_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;

    // Pipeline sideband
    typedef struct packed {
        logic                     valid;
        logic [KIND_W-1:0]        kind;
        logic                     apply;
        logic                     err;
        logic                     m_zero;
        logic signed [DATA_W-1:0] tap;
    } fwwg_side_t;

    typedef struct packed {
        logic [DATA_W-1:0] weight;
        logic              index_error;
    } fwwg_res_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2FA;
            15:      a = 32'h0000517D;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A30;
            19:      a = 32'h00000518;
            20:      a = 32'h0000028C;
            21:      a = 32'h00000146;
            22:      a = 32'h000000A3;
            23:      a = 32'h00000051;
            24:      a = 32'h00000029;
            25:      a = 32'h00000014;
            26:      a = 32'h0000000A;
            27:      a = 32'h00000005;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

### rtl/fwwg_if.sv
// Valid/ready channel interfaces for tap words and weight words.
interface fwwg_in_if
    import fwwg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] tap_value;

    modport source (output valid, output tap_index, output tap_value, input ready);
    modport sink   (input valid, input tap_index, input tap_value, output ready);
endinterface

interface fwwg_out_if
    import fwwg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] weight;
    logic                     index_error;

    modport source (output valid, output weight, output index_error, input ready);
    modport sink   (input valid, input weight, input index_error, output ready);
endinterface

### rtl/fir_window_weight_generator.sv
// Throughput: one word per cycle while the skid is empty; an input stage, a
// 32-stage divider, two 30-stage CORDIC lanes, five arithmetic stages and the
// output register carry every index. A two-entry output skid lets one more word
// in while a result waits. Reset clears all valid bits and sets kind rectangular,
// length 64, apply off. Top level: FIR window weight generator.
module fir_window_weight_generator
    import fwwg_pkg::*;
#(
    parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fwwg_in_if.sink               tap_in,
    fwwg_out_if.source            weight_out
);

    localparam int W_SHIFT = 30 - FRACTION_BITS;
    localparam logic signed [63:0] RND_W = (W_SHIFT == 0) ? 64'sd0 : (64'sd1 <<< (W_SHIFT - 1));
    localparam logic signed [63:0] RND_P = 64'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [63:0] RND_Q = 64'sd1 <<< 29;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Configuration registers
    logic [KIND_W-1:0] kind_reg;
    logic [M_W-1:0]    length_reg;
    logic              apply_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_RECT;
            length_reg <= LENGTH_RESET;
            apply_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KIND:   kind_reg   <= cfg_data[KIND_W-1:0];
                REG_LENGTH: length_reg <= cfg_data[M_W-1:0];
                REG_APPLY:  apply_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Pipeline enable: the whole pipe advances while the skid is empty
    logic en;
    logic skid_valid_reg;
    assign en = !skid_valid_reg;
    assign tap_in.ready = en;

    // Stage 0: capture the word and the configuration
    logic [M_W-1:0] len_c;
    fwwg_side_t     side_in;

    always_comb
    begin
        len_c = (32'(length_reg) > MAX_LENGTH) ? M_W'(MAX_LENGTH) : length_reg;
        side_in.valid  = tap_in.valid;
        side_in.kind   = kind_reg;
        side_in.apply  = apply_reg;
        side_in.err    = {1'b0, tap_in.tap_index} >= len_c;
        side_in.m_zero = len_c == M_W'(1);
        side_in.tap    = tap_in.tap_value;
    end

    fwwg_side_t     s0_side_reg;
    logic [IDX_W-1:0] s0_n_reg;
    logic [M_W-1:0]   s0_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_side_reg <= '0;
        else if (en)
            s0_side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_n_reg <= tap_in.tap_index;
            s0_m_reg <= len_c - M_W'(1);
        end
    end

    // Divider numerator: phase n/m of a turn, or Bartlett distance over m
    logic [M_W-1:0]   n_ext;
    logic [M_W-1:0]   n_ph;
    logic [M_W-1:0]   two_n;
    logic [M_W-1:0]   gap;
    logic [NUM_W-1:0] half_m;
    logic [NUM_W-1:0] num;

    always_comb
    begin
        n_ext  = {1'b0, s0_n_reg};
        n_ph   = (n_ext == s0_m_reg) ? '0 : n_ext;
        two_n  = {s0_n_reg, 1'b0};
        gap    = (two_n >= s0_m_reg) ? two_n - s0_m_reg : s0_m_reg - two_n;
        half_m = NUM_W'(s0_m_reg >> 1);
        if (s0_side_reg.kind == KIND_BARTLETT)
            num = (NUM_W'(gap) << 30) | half_m;
        else
            num = {n_ph, {PH_W{1'b0}}} | half_m;
    end

    logic [PH_W-1:0] quot;

    fwwg_divider u_div (
        .clk  (clk),
        .en   (en),
        .num  (num),
        .den  (s0_m_reg),
        .quot (quot)
    );

    // Sideband alongside the divider and the CORDIC lanes
    fwwg_side_t      div_side_reg [DIV_LAT];
    fwwg_side_t      cor_side_reg [COR_LAT];
    logic [PH_W-1:0] cor_quot_reg [COR_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                div_side_reg[i] <= '0;
            for (int i = 0; i < COR_LAT; i++)
                cor_side_reg[i] <= '0;
        end
        else if (en)
        begin
            div_side_reg[0] <= s0_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                div_side_reg[i] <= div_side_reg[i-1];
            cor_side_reg[0] <= div_side_reg[DIV_LAT-1];
            for (int i = 1; i < COR_LAT; i++)
                cor_side_reg[i] <= cor_side_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cor_quot_reg[0] <= quot;
            for (int i = 1; i < COR_LAT; i++)
                cor_quot_reg[i] <= cor_quot_reg[i-1];
        end
    end

    logic signed [DATA_W-1:0] cos1;
    logic signed [DATA_W-1:0] cos2;

    fwwg_cordic u_cos1 (
        .clk     (clk),
        .en      (en),
        .phase   (quot),
        .cos_val (cos1)
    );

    fwwg_cordic u_cos2 (
        .clk     (clk),
        .en      (en),
        .phase   ({quot[PH_W-2:0], 1'b0}),
        .cos_val (cos2)
    );

    // Stage A: cosine products and the constant term
    fwwg_side_t               cs;
    logic [PH_W-1:0]          cq;
    logic signed [DATA_W-1:0] coef1;
    logic signed [DATA_W-1:0] base_c;
    logic                     use1_c;
    logic                     use2_c;

    always_comb
    begin
        cs     = cor_side_reg[COR_LAT-1];
        cq     = cor_quot_reg[COR_LAT-1];
        coef1  = (cs.kind == KIND_HAMMING) ? C046 : C050;
        base_c = Q_ONE;
        use1_c = 1'b0;
        use2_c = 1'b0;
        case (cs.kind)
            KIND_BARTLETT:
                base_c = Q_ONE - $signed(cq);
            KIND_HANN:
            begin
                base_c = C050;
                use1_c = 1'b1;
            end
            KIND_HAMMING:
            begin
                base_c = C054;
                use1_c = 1'b1;
            end
            KIND_BLACKMAN:
            begin
                base_c = C042;
                use1_c = 1'b1;
                use2_c = 1'b1;
            end
            default:
                base_c = Q_ONE;
        endcase
        if (cs.m_zero)
        begin
            base_c = Q_ONE;
            use1_c = 1'b0;
            use2_c = 1'b0;
        end
    end

    fwwg_side_t               a_side_reg;
    logic signed [63:0]       a_prod1_reg;
    logic signed [63:0]       a_prod2_reg;
    logic signed [DATA_W-1:0] a_base_reg;
    logic                     a_use1_reg;
    logic                     a_use2_reg;

    // Stage B: Q1.30 weight
    fwwg_side_t               b_side_reg;
    logic signed [DATA_W-1:0] b_w_reg;
    logic signed [63:0]       term1;
    logic signed [63:0]       term2;
    logic signed [63:0]       b_sum;

    always_comb
    begin
        term1 = a_use1_reg ? ((a_prod1_reg + RND_Q) >>> 30) : 64'sd0;
        term2 = a_use2_reg ? ((a_prod2_reg + RND_Q) >>> 30) : 64'sd0;
        b_sum = 64'(a_base_reg) - term1 + term2;
    end

    // Stage C: weight rounded to the output fraction
    fwwg_side_t               c_side_reg;
    logic signed [DATA_W-1:0] c_w_reg;
    logic signed [63:0]       c_round;

    assign c_round = (64'(b_w_reg) + RND_W) >>> W_SHIFT;

    // Stage D: weighted tap product
    fwwg_side_t               d_side_reg;
    logic signed [DATA_W-1:0] d_w_reg;
    logic signed [63:0]       d_prod_reg;

    // Stage E: round, saturate, select
    fwwg_res_t          e_res_reg;
    logic               e_valid_reg;
    logic signed [63:0] p_round;
    logic signed [DATA_W-1:0] p_sat;
    fwwg_res_t          e_res_c;

    always_comb
    begin
        p_round = (d_prod_reg + RND_P) >>> FRACTION_BITS;
        if (p_round > SAT_HI)
            p_sat = 32'sh7FFFFFFF;
        else if (p_round < SAT_LO)
            p_sat = 32'sh80000000;
        else
            p_sat = $signed(p_round[DATA_W-1:0]);
        e_res_c.index_error = d_side_reg.err;
        if (d_side_reg.err)
            e_res_c.weight = '0;
        else if (d_side_reg.apply)
            e_res_c.weight = p_sat;
        else
            e_res_c.weight = d_w_reg;
    end

    // Advance the valid bits of the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg  <= '0;
            b_side_reg  <= '0;
            c_side_reg  <= '0;
            d_side_reg  <= '0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_side_reg  <= cs;
            b_side_reg  <= a_side_reg;
            c_side_reg  <= b_side_reg;
            d_side_reg  <= c_side_reg;
            e_valid_reg <= d_side_reg.valid;
        end
    end

    // Advance the arithmetic payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod1_reg <= coef1 * cos1;
            a_prod2_reg <= C008 * cos2;
            a_base_reg  <= base_c;
            a_use1_reg  <= use1_c;
            a_use2_reg  <= use2_c;
            b_w_reg     <= $signed(b_sum[DATA_W-1:0]);
            c_w_reg     <= $signed(c_round[DATA_W-1:0]);
            d_w_reg     <= c_w_reg;
            d_prod_reg  <= c_w_reg * c_side_reg.tap;
            e_res_reg   <= e_res_c;
        end
    end

    // Output register with skid entry
    fwwg_res_t main_reg;
    fwwg_res_t skid_reg;
    logic      main_valid_reg;
    logic      push;
    logic      pop;

    assign push = e_valid_reg && en;
    assign pop  = main_valid_reg && weight_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= push;
        end
        else if (push)
        begin
            if (!main_valid_reg)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= e_res_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg)
                main_reg <= e_res_reg;
            else
                skid_reg <= e_res_reg;
        end
    end

    assign weight_out.valid       = main_valid_reg;
    assign weight_out.weight      = $signed(main_reg.weight);
    assign weight_out.index_error = main_reg.index_error;

`ifndef SYNTH
    a_skid_needs_main : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without an output word");

    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && main_reg.index_error) |-> (main_reg.weight == '0))
        else $error("out-of-range index with nonzero weight");

    a_rect_one : assert property (@(posedge clk) disable iff (!rst_n)
        (b_side_reg.valid && (b_side_reg.kind == KIND_RECT)) |-> (b_w_reg == Q_ONE))
        else $error("rectangular weight is not one");
`endif

endmodule

### rtl/fwwg_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module fwwg_divider
    import fwwg_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [M_W-1:0]   den,
    output logic [PH_W-1:0]  quot
);

    logic [M_W-1:0]  rem_reg [PH_W];
    logic [PH_W-1:0] low_reg [PH_W];
    logic [PH_W-1:0] quot_reg [PH_W];
    logic [M_W-1:0]  den_reg [PH_W];

    for (genvar k = 0; k < PH_W; k++) begin : g_step
        logic [M_W-1:0]  rem_src;
        logic [PH_W-1:0] low_src;
        logic [PH_W-1:0] quot_src;
        logic [M_W-1:0]  den_src;
        logic [M_W:0]    trial;

        // Pick the previous partial remainder
        if (k == 0) begin : g_first
            assign rem_src  = num[NUM_W-1:PH_W];
            assign low_src  = num[PH_W-1:0];
            assign quot_src = '0;
            assign den_src  = den;
        end else begin : g_next
            assign rem_src  = rem_reg[k-1];
            assign low_src  = low_reg[k-1];
            assign quot_src = quot_reg[k-1];
            assign den_src  = den_reg[k-1];
        end

        assign trial = {rem_src, low_src[PH_W-1]};

        // Shift in one numerator bit, subtract when it fits
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, den_src})
                begin
                    rem_reg[k]  <= M_W'(trial - {1'b0, den_src});
                    quot_reg[k] <= {quot_src[PH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= trial[M_W-1:0];
                    quot_reg[k] <= {quot_src[PH_W-2:0], 1'b0};
                end
                low_reg[k] <= {low_src[PH_W-2:0], 1'b0};
                den_reg[k] <= den_src;
            end
        end
    end

    assign quot = quot_reg[PH_W-1];

endmodule

### rtl/fwwg_cordic.sv
// Pipelined rotation-mode CORDIC cosine, one micro-rotation per stage.
module fwwg_cordic
    import fwwg_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [PH_W-1:0]          phase,
    output logic signed [DATA_W-1:0] cos_val
);

    localparam logic signed [CORDIC_W-1:0] ONE_W = CORDIC_W'(Q_ONE);

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                       neg_reg [CORDIC_STEPS+1];
    logic signed [DATA_W-1:0]   cos_reg;

    logic            pre_neg;
    logic [PH_W-1:0] pre_phase;

    // Fold the back half-turn onto the front half
    assign pre_neg   = phase[PH_W-1] ^ phase[PH_W-2];
    assign pre_phase = pre_neg ? {~phase[PH_W-1], phase[PH_W-2:0]} : phase;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_W'(CORDIC_GAIN_INV);
            y_reg[0]   <= '0;
            z_reg[0]   <= CORDIC_W'($signed(pre_phase));
            neg_reg[0] <= pre_neg;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        localparam logic signed [CORDIC_W-1:0] ATAN_K =
            $signed({{(CORDIC_W-32){1'b0}}, atan_turn(k)});
        logic signed [CORDIC_W-1:0] x_sh;
        logic signed [CORDIC_W-1:0] y_sh;

        assign x_sh = x_reg[k] >>> k;
        assign y_sh = y_reg[k] >>> k;

        // Rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[k][CORDIC_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] - y_sh;
                    y_reg[k+1] <= y_reg[k] + x_sh;
                    z_reg[k+1] <= z_reg[k] - ATAN_K;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + y_sh;
                    y_reg[k+1] <= y_reg[k] - x_sh;
                    z_reg[k+1] <= z_reg[k] + ATAN_K;
                end
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Clamp to plus or minus one, restore the sign
    logic signed [CORDIC_W-1:0] x_clamp;
    logic signed [CORDIC_W-1:0] x_final;

    always_comb
    begin
        x_clamp = x_reg[CORDIC_STEPS];
        if (x_clamp > ONE_W)
            x_clamp = ONE_W;
        if (x_clamp < -ONE_W)
            x_clamp = -ONE_W;
        x_final = neg_reg[CORDIC_STEPS] ? -x_clamp : x_clamp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cos_reg <= $signed(x_final[DATA_W-1:0]);
    end

    assign cos_val = cos_reg;

endmodule
